@@ sv/pwcf_pkg.sv @@
// pwcf_pkg: types, constants and the CORDIC angle table for the plane-wave coefficient fit.
// No dependencies; imported by plane_wave_coefficient_fit.
package pwcf_pkg;

    localparam int ACC_WIDTH_DEF = 64;
    localparam int TRIG_BITS_DEF = 16;
    localparam int CORDIC_MAX    = 24;
    localparam int MUL_W         = 34;
    localparam int CW            = 34;
    localparam int IDX_W         = 3;
    localparam int CFG_W         = 32;

    localparam logic [IDX_W-1:0] REG_WAVENUMBER = 3'd0;
    localparam logic [IDX_W-1:0] REG_WAVE_SPEED = 3'd1;
    localparam logic [IDX_W-1:0] REG_PHASE_OFF  = 3'd2;
    localparam logic [IDX_W-1:0] REG_INC_AMP    = 3'd3;
    localparam logic [IDX_W-1:0] REG_INC_PHASE  = 3'd4;
    localparam logic [IDX_W-1:0] REG_REFL_MODE  = 3'd5;

    localparam logic signed [31:0] WAVENUMBER_RST = 32'sd16777216;
    localparam logic [30:0]        WAVE_SPEED_RST = 31'd16777216;
    localparam logic signed [31:0] PHASE_OFF_RST  = 32'sd4194304;
    localparam logic signed [31:0] INC_AMP_RST    = 32'sd16777216;
    localparam logic signed [31:0] INC_PHASE_RST  = 32'sd0;

    localparam logic signed [CW-1:0] INV_GAIN_Q30 = 34'sd652032874;
    localparam logic [63:0]          SAT_MAG      = 64'h0000_0000_8000_0000;
    localparam logic [7:0]           DIV_STEPS    = 8'd64;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] field_sample;
        logic signed [31:0] sample_time;
        logic               is_last;
    } in_t;

    typedef struct packed {
        logic signed [31:0] coeff_real;
        logic signed [31:0] coeff_imag;
        logic               degenerate;
    } out_t;

    typedef enum logic [4:0] {
        S_IDLE, S_FREQ, S_WTLO, S_WTHI, S_PHD, S_PH1, S_PH2,
        S_CINIT, S_CRUN, S_CDONE, S_AMP, S_U,
        S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
        S_NORM, S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6,
        S_DINIT, S_DRUN, S_DFIN, S_DONE
    } state_t;

    // atan(2^-i) in units of 2^-32 of a full turn
    function automatic logic [29:0] cordic_angle(input logic [4:0] i);
        logic [29:0] r;
        case (i)
            5'd0:    r = 30'd536870912;
            5'd1:    r = 30'd316933406;
            5'd2:    r = 30'd167458907;
            5'd3:    r = 30'd85004756;
            5'd4:    r = 30'd42667331;
            5'd5:    r = 30'd21354465;
            5'd6:    r = 30'd10679838;
            5'd7:    r = 30'd5340245;
            5'd8:    r = 30'd2670163;
            5'd9:    r = 30'd1335087;
            5'd10:   r = 30'd667544;
            5'd11:   r = 30'd333772;
            5'd12:   r = 30'd166886;
            5'd13:   r = 30'd83443;
            5'd14:   r = 30'd41722;
            5'd15:   r = 30'd20861;
            5'd16:   r = 30'd10430;
            5'd17:   r = 30'd5215;
            5'd18:   r = 30'd2608;
            5'd19:   r = 30'd1304;
            5'd20:   r = 30'd652;
            5'd21:   r = 30'd326;
            5'd22:   r = 30'd163;
            5'd23:   r = 30'd81;
            default: r = 30'd0;
        endcase
        return r;
    endfunction

endpackage

@@ sv/plane_wave_coefficient_fit.sv @@
// plane_wave_coefficient_fit: least-squares fit of a plane-wave coefficient, one shared
// multiplier, CORDIC and bit-serial divider under a single sequencer. Depends on pwcf_pkg.
//
//   channel   | signals                          | direction
//   ----------+----------------------------------+----------
//   input     | in_valid, in_stall, in_data      | in
//   output    | out_valid, out_stall, out_data   | out
//   config    | cfg_wr_en, cfg_index, cfg_wdata  | in
//
// Each sample runs a sine/cosine through N = min(TRIG_BITS, 24) CORDIC steps; reflection
// mode adds a second one and the incident-term subtraction.
// The last sample of a run adds the normalisation shifts, the multiply steps S_P0 to S_P6
// and two bit-serial divisions, then the result is registered into the output register.
// rst_n clears control and the five sums and resets configuration; in_stall is high while
// a sample is in work. A held result stalls the sequencer only at its final step.
module plane_wave_coefficient_fit
    import pwcf_pkg::*;
#(
    parameter int ACC_WIDTH = ACC_WIDTH_DEF,
    parameter int TRIG_BITS = TRIG_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  in_t              in_data,
    output logic             out_valid,
    input  logic             out_stall,
    output out_t             out_data,
    input  logic             cfg_wr_en,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_wdata
);

    localparam int N_ITER = (TRIG_BITS < CORDIC_MAX) ? TRIG_BITS : CORDIC_MAX;
    localparam int IW     = 5;
    localparam logic [IW-1:0] LAST_ITER = IW'(N_ITER - 1);

    logic signed [31:0] kw_reg, off_reg, amp_reg, iph_reg;
    logic [30:0]        spd_reg;
    logic               refl_reg;

    state_t state_reg, state_next;
    in_t    in_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod_reg;

    logic signed [39:0] freq_reg;
    logic [47:0]        wt_reg, ph1_reg, ph2_reg;
    logic               second_reg;

    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic [1:0]           quad_reg;
    logic [IW-1:0]        iter_reg;

    logic signed [MUL_W-1:0] sn_reg, cs_reg, si_reg, u_reg;

    logic signed [ACC_WIDTH-1:0] acc_ss_reg, acc_sc_reg, acc_cc_reg, acc_sf_reg, acc_cf_reg;
    logic [5:0] sa_reg, sb_reg;

    logic signed [63:0] dn_reg, nre_reg, nim_reg;
    logic               degen_reg, im_sel_reg, neg_reg;
    logic [63:0]        dvd_reg, ud_reg, quo_reg, rem_reg;
    logic [7:0]         dcnt_reg;
    logic signed [7:0]  e_reg;
    logic signed [31:0] re_reg, im_reg;

    out_t out_reg;
    logic out_valid_reg;

    function automatic logic signed [MUL_W-1:0] sx32(input logic [31:0] v);
        return {{(MUL_W-32){v[31]}}, v};
    endfunction

    function automatic logic signed [MUL_W-1:0] sx31(input logic [30:0] v);
        return {{(MUL_W-31){v[30]}}, v};
    endfunction

    function automatic logic in_rng(input logic [ACC_WIDTH-1:0] v);
        return (v[ACC_WIDTH-1:30] == '0) || (v[ACC_WIDTH-1:30] == '1);
    endfunction

    // ---------------- handshake ----------------
    logic in_acc, out_free;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------- CORDIC ----------------
    logic [47:0]          ph_sel;
    logic [31:0]          a_val, q_sum, ra;
    logic [1:0]           q_val;
    logic signed [CW-1:0] xsh, ysh, ang, c_val, s_val, c_rnd, s_rnd;

    always_comb
    begin
        ph_sel = second_reg ? ph2_reg : ph1_reg;
        a_val  = {ph_sel[47 -: TRIG_BITS], {(32-TRIG_BITS){1'b0}}};
        q_sum  = a_val + 32'h2000_0000;
        q_val  = q_sum[31:30];
        ra     = a_val - {q_val, 30'd0};
        xsh    = cx_reg >>> iter_reg;
        ysh    = cy_reg >>> iter_reg;
        ang    = {{(CW-30){1'b0}}, cordic_angle(iter_reg)};
        case (quad_reg)
            2'd0:    begin c_val = cx_reg;  s_val = cy_reg;  end
            2'd1:    begin c_val = -cy_reg; s_val = cx_reg;  end
            2'd2:    begin c_val = -cx_reg; s_val = -cy_reg; end
            default: begin c_val = cy_reg;  s_val = -cx_reg; end
        endcase
        c_rnd = (c_val + CW'(32)) >>> 6;
        s_rnd = (s_val + CW'(32)) >>> 6;
    end

    // ---------------- normalisation ----------------
    logic mat_ok, rhs_ok, mat_done, rhs_done;
    assign mat_ok   = in_rng(acc_ss_reg) && in_rng(acc_sc_reg) && in_rng(acc_cc_reg);
    assign rhs_ok   = in_rng(acc_sf_reg) && in_rng(acc_cf_reg);
    assign mat_done = mat_ok || (sa_reg == 6'd63);
    assign rhs_done = rhs_ok || (sb_reg == 6'd63);

    logic signed [MUL_W-1:0] m0, m1, m2, r0, r1;
    assign m0 = sx31(acc_ss_reg[30:0]);
    assign m1 = sx31(acc_sc_reg[30:0]);
    assign m2 = sx31(acc_cc_reg[30:0]);
    assign r0 = sx31(acc_sf_reg[30:0]);
    assign r1 = sx31(acc_cf_reg[30:0]);

    // ---------------- divider ----------------
    logic signed [63:0] n_sel, d_sel;
    logic               dz;
    logic [63:0]        un, ud;
    logic signed [7:0]  e_val;
    logic               step_main, step_ext, div_go, bit_in;
    logic [64:0]        r2;
    logic               r_ge;
    logic [7:0]         shr;
    logic [63:0]        qsh, qs;
    logic signed [31:0] div_res;
    logic signed [MUL_W-1:0] u_new;
    logic signed [2*MUL_W-1:0] amp_rnd;

    always_comb
    begin
        n_sel = im_sel_reg ? nim_reg : nre_reg;
        dz    = (dn_reg == 64'sd0);
        d_sel = dz ? 64'sd1 : dn_reg;
        un    = n_sel[63] ? 64'(-n_sel) : 64'(n_sel);
        ud    = d_sel[63] ? 64'(-d_sel) : 64'(d_sel);
        if (dz)
            e_val = 8'(signed'({2'b00, sa_reg}) + signed'({2'b00, sb_reg}) - 8'sd72);
        else
            e_val = 8'(signed'({2'b00, sb_reg}) - signed'({2'b00, sa_reg}) + 8'sd24);

        step_main = (dcnt_reg < DIV_STEPS);
        step_ext  = !e_reg[7] && (e_reg != 8'sd0) &&
                    (dcnt_reg < (DIV_STEPS + 8'(e_reg))) && (quo_reg <= SAT_MAG);
        div_go    = step_main || step_ext;
        bit_in    = step_main ? dvd_reg[63] : 1'b0;
        r2        = {rem_reg, bit_in};
        r_ge      = (r2 >= {1'b0, ud_reg});

        shr = 8'(-e_reg);
        if (e_reg[7])
            qsh = (shr >= 8'd64) ? 64'd0 : (quo_reg >> shr[5:0]);
        else
            qsh = quo_reg;
        qs = (qsh > SAT_MAG) ? SAT_MAG : qsh;
        if (neg_reg)
            div_res = 32'(-qs);
        else
            div_res = (qs > SAT_MAG - 64'd1) ? 32'sh7FFF_FFFF : 32'(qs);

        amp_rnd = prod_reg + (2*MUL_W)'(64'd8388608);
        u_new   = sx32(in_reg.field_sample) - amp_rnd[MUL_W+23:24];
    end

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_acc) state_next = S_FREQ;
            S_FREQ:  state_next = S_WTLO;
            S_WTLO:  state_next = S_WTHI;
            S_WTHI:  state_next = S_PHD;
            S_PHD:   state_next = S_PH1;
            S_PH1:   state_next = S_PH2;
            S_PH2:   state_next = S_CINIT;
            S_CINIT: state_next = S_CRUN;
            S_CRUN:  if (iter_reg == LAST_ITER) state_next = S_CDONE;
            S_CDONE:
            begin
                if (second_reg)
                    state_next = S_AMP;
                else if (refl_reg)
                    state_next = S_CINIT;
                else
                    state_next = S_M0;
            end
            S_AMP:   state_next = S_U;
            S_U:     state_next = S_M0;
            S_M0:    state_next = S_M1;
            S_M1:    state_next = S_M2;
            S_M2:    state_next = S_M3;
            S_M3:    state_next = S_M4;
            S_M4:    state_next = S_M5;
            S_M5:    state_next = in_reg.is_last ? S_NORM : S_IDLE;
            S_NORM:  if (mat_done && rhs_done) state_next = S_P0;
            S_P0:    state_next = S_P1;
            S_P1:    state_next = S_P2;
            S_P2:    state_next = S_P3;
            S_P3:    state_next = S_P4;
            S_P4:    state_next = S_P5;
            S_P5:    state_next = S_P6;
            S_P6:    state_next = S_DINIT;
            S_DINIT: state_next = S_DRUN;
            S_DRUN:  if (!div_go) state_next = S_DFIN;
            S_DFIN:  state_next = im_sel_reg ? S_DONE : S_DINIT;
            S_DONE:  if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // ---------------- multiplier operands ----------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_FREQ:
            begin
                mul_a = sx32(kw_reg);
                mul_b = {{(MUL_W-31){1'b0}}, spd_reg};
            end
            S_WTLO:
            begin
                mul_a = {{(MUL_W-24){1'b0}}, prod_reg[47:24]};
                mul_b = sx32(in_reg.sample_time);
            end
            S_WTHI:
            begin
                mul_a = {{(MUL_W-16){freq_reg[39]}}, freq_reg[39:24]};
                mul_b = sx32(in_reg.sample_time);
            end
            S_PHD:
            begin
                mul_a = sx32(kw_reg);
                mul_b = sx32(in_reg.position_x) - sx32(off_reg);
            end
            S_PH1:
            begin
                mul_a = sx32(kw_reg);
                mul_b = sx32(in_reg.position_x);
            end
            S_AMP:   begin mul_a = sx32(amp_reg); mul_b = si_reg; end
            S_M0:    begin mul_a = sn_reg; mul_b = sn_reg; end
            S_M1:    begin mul_a = sn_reg; mul_b = cs_reg; end
            S_M2:    begin mul_a = cs_reg; mul_b = cs_reg; end
            S_M3:    begin mul_a = sn_reg; mul_b = u_reg;  end
            S_M4:    begin mul_a = cs_reg; mul_b = u_reg;  end
            S_P0:    begin mul_a = m0; mul_b = m2; end
            S_P1:    begin mul_a = m1; mul_b = m1; end
            S_P2:    begin mul_a = m2; mul_b = r0; end
            S_P3:    begin mul_a = m1; mul_b = r1; end
            S_P4:    begin mul_a = m0; mul_b = r1; end
            S_P5:    begin mul_a = m1; mul_b = r0; end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end

    // ---------------- control, configuration and sums ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            kw_reg        <= WAVENUMBER_RST;
            spd_reg       <= WAVE_SPEED_RST;
            off_reg       <= PHASE_OFF_RST;
            amp_reg       <= INC_AMP_RST;
            iph_reg       <= INC_PHASE_RST;
            refl_reg      <= 1'b0;
            acc_ss_reg    <= '0;
            acc_sc_reg    <= '0;
            acc_cc_reg    <= '0;
            acc_sf_reg    <= '0;
            acc_cf_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_WAVENUMBER: kw_reg   <= cfg_wdata;
                    REG_WAVE_SPEED: spd_reg  <= cfg_wdata[30:0];
                    REG_PHASE_OFF:  off_reg  <= cfg_wdata;
                    REG_INC_AMP:    amp_reg  <= cfg_wdata;
                    REG_INC_PHASE:  iph_reg  <= cfg_wdata;
                    REG_REFL_MODE:  refl_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_M1: acc_ss_reg <= acc_ss_reg + prod_reg[ACC_WIDTH-1:0];
                S_M2: acc_sc_reg <= acc_sc_reg + prod_reg[ACC_WIDTH-1:0];
                S_M3: acc_cc_reg <= acc_cc_reg + prod_reg[ACC_WIDTH-1:0];
                S_M4: acc_sf_reg <= acc_sf_reg + prod_reg[ACC_WIDTH-1:0];
                S_M5: acc_cf_reg <= acc_cf_reg + prod_reg[ACC_WIDTH-1:0];
                S_NORM:
                begin
                    if (!mat_done)
                    begin
                        acc_ss_reg <= acc_ss_reg >>> 1;
                        acc_sc_reg <= acc_sc_reg >>> 1;
                        acc_cc_reg <= acc_cc_reg >>> 1;
                    end
                    if (!rhs_done)
                    begin
                        acc_sf_reg <= acc_sf_reg >>> 1;
                        acc_cf_reg <= acc_cf_reg >>> 1;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        acc_ss_reg <= '0;
                        acc_sc_reg <= '0;
                        acc_cc_reg <= '0;
                        acc_sf_reg <= '0;
                        acc_cf_reg <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;

        if (in_acc)
        begin
            in_reg     <= in_data;
            u_reg      <= sx32(in_data.field_sample);
            second_reg <= 1'b0;
        end

        case (state_reg)
            S_WTLO: freq_reg <= prod_reg[63:24];
            S_WTHI: wt_reg   <= prod_reg[47:0];
            S_PHD:  wt_reg   <= wt_reg + {prod_reg[23:0], 24'd0};
            S_PH1:  ph1_reg  <= (refl_reg ? 48'(-prod_reg[47:0]) : prod_reg[47:0]) - wt_reg;
            S_PH2:  ph2_reg  <= prod_reg[47:0] - wt_reg - {iph_reg[23:0], 24'd0};
            S_CINIT:
            begin
                cx_reg   <= INV_GAIN_Q30;
                cy_reg   <= '0;
                cz_reg   <= {{(CW-32){ra[31]}}, ra};
                quad_reg <= q_val;
                iter_reg <= '0;
            end
            S_CRUN:
            begin
                if (!cz_reg[CW-1])
                begin
                    cx_reg <= cx_reg - ysh;
                    cy_reg <= cy_reg + xsh;
                    cz_reg <= cz_reg - ang;
                end
                else
                begin
                    cx_reg <= cx_reg + ysh;
                    cy_reg <= cy_reg - xsh;
                    cz_reg <= cz_reg + ang;
                end
                iter_reg <= iter_reg + 1'b1;
            end
            S_CDONE:
            begin
                if (second_reg)
                    si_reg <= MUL_W'(s_rnd);
                else
                begin
                    sn_reg     <= MUL_W'(s_rnd);
                    cs_reg     <= MUL_W'(c_rnd);
                    second_reg <= refl_reg;
                end
            end
            S_U:  u_reg <= u_new;
            S_M5:
            begin
                sa_reg <= '0;
                sb_reg <= '0;
            end
            S_NORM:
            begin
                if (!mat_done) sa_reg <= sa_reg + 1'b1;
                if (!rhs_done) sb_reg <= sb_reg + 1'b1;
            end
            S_P1: dn_reg  <= prod_reg[63:0];
            S_P2: dn_reg  <= dn_reg - prod_reg[63:0];
            S_P3: nre_reg <= prod_reg[63:0];
            S_P4: nre_reg <= nre_reg - prod_reg[63:0];
            S_P5: nim_reg <= prod_reg[63:0];
            S_P6:
            begin
                nim_reg    <= nim_reg - prod_reg[63:0];
                im_sel_reg <= 1'b0;
            end
            S_DINIT:
            begin
                dvd_reg   <= un;
                ud_reg    <= ud;
                neg_reg   <= n_sel[63] ^ d_sel[63];
                e_reg     <= e_val;
                degen_reg <= dz;
                rem_reg   <= '0;
                quo_reg   <= '0;
                dcnt_reg  <= '0;
            end
            S_DRUN:
            begin
                if (div_go)
                begin
                    dvd_reg  <= {dvd_reg[62:0], 1'b0};
                    rem_reg  <= r_ge ? 64'(r2 - {1'b0, ud_reg}) : r2[63:0];
                    quo_reg  <= {quo_reg[62:0], r_ge};
                    dcnt_reg <= dcnt_reg + 1'b1;
                end
            end
            S_DFIN:
            begin
                if (im_sel_reg)
                    im_reg <= div_res;
                else
                    re_reg <= div_res;
                im_sel_reg <= 1'b1;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_reg.coeff_real <= re_reg;
                    out_reg.coeff_imag <= im_reg;
                    out_reg.degenerate <= degen_reg;
                end
            end
            default: ;
        endcase
    end

    // ---------------- assertions ----------------
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside final step");

    a_norm_fit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_P0) |-> ((mat_ok || sa_reg == 6'd63) && (rhs_ok || sb_reg == 6'd63)))
        else $error("normalised sums out of range");

    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRUN) |-> (dcnt_reg <= 8'd151))
        else $error("divider step count overrun");

    a_sums_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_free) |=> (acc_ss_reg == '0 && acc_cf_reg == '0))
        else $error("sums not cleared after result");

endmodule
